/* hdl/pid_controller_step_macros.svh */
// Assertion macros used by the checker file of the PID step block.
// Depends on nothing; each macro expects clk and rst_n in the using scope.
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

// Same-cycle implication, masked during reset
`define PIDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidc check failed: same-cycle rule");

// Next-cycle implication, masked during reset
`define PIDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidc check failed: next-cycle rule");

`endif

/* hdl/pidc_pkg.sv */
// Shared types and constants of the PID step block.
// No dependencies; used by every module of the block but the queue.
package pidc_pkg;

  localparam int DATA_W     = 16;
  localparam int ERR_W      = DATA_W + 1;
  localparam int SUM_W      = 32;
  localparam int PROD_PD_W  = DATA_W + ERR_W;
  localparam int PROD_I_W   = DATA_W + SUM_W;
  localparam int ACC_W      = PROD_I_W + 2;

  localparam logic [DATA_W-1:0] DRIVE_MAX = 16'hFFFF;

  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_KP = 2'd0;
  localparam logic [1:0] REG_KI = 2'd1;
  localparam logic [1:0] REG_KD = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
  } gains_t;

  // one classified sample, handed from front to back
  typedef struct packed {
    logic                     first;
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  isum;
    logic signed [ERR_W-1:0]  delta;
  } task_t;

endpackage

/* hdl/pidc_fifo.sv */
// Small first-word-fall-through queue built from flops.
// No package dependency; DEPTH must be a power of two, at least 2.
module pidc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(do_pop);
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hdl/pidc_cfg.sv */
// APB-style register file holding the three PID gains.
// Depends on pidc_pkg for the register codes and the gains struct.
module pidc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pidc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output pidc_pkg::gains_t                    gains
);

  pidc_pkg::gains_t gains_r, gains_nxt;
  logic [1:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign gains   = gains_r;

  // register write decode; bits above 15 are dropped
  always_comb begin
    gains_nxt = gains_r;
    if (wr_en) begin
      case (reg_idx)
        pidc_pkg::REG_KP: gains_nxt.kp = pwdata[pidc_pkg::DATA_W-1:0];
        pidc_pkg::REG_KI: gains_nxt.ki = pwdata[pidc_pkg::DATA_W-1:0];
        pidc_pkg::REG_KD: gains_nxt.kd = pwdata[pidc_pkg::DATA_W-1:0];
        default: gains_nxt = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  // read back, sign-extended
  always_comb begin
    case (reg_idx)
      pidc_pkg::REG_KP: prdata = pidc_pkg::CFG_DATA_W'(gains_r.kp);
      pidc_pkg::REG_KI: prdata = pidc_pkg::CFG_DATA_W'(gains_r.ki);
      pidc_pkg::REG_KD: prdata = pidc_pkg::CFG_DATA_W'(gains_r.kd);
      default:          prdata = '0;
    endcase
  end

endmodule

/* hdl/pidc_front.sv */
// Front end: takes samples, keeps the loop state, classifies each item.
// Depends on pidc_pkg for the task record and widths.
module pidc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic signed [pidc_pkg::DATA_W-1:0] setpoint,
  input  logic signed [pidc_pkg::DATA_W-1:0] measurement,
  output pidc_pkg::task_t                  task_out
);

  localparam int DW = pidc_pkg::DATA_W;
  localparam int EW = pidc_pkg::ERR_W;
  localparam int SW = pidc_pkg::SUM_W;

  logic                 armed_r, armed_nxt;
  logic signed [SW-1:0] isum_r, isum_nxt;
  logic signed [DW-1:0] last_meas_r, last_meas_nxt;

  logic signed [EW-1:0] err;
  logic signed [EW-1:0] delta;
  logic signed [SW:0]   sum_wide;
  logic signed [SW-1:0] sum_sat;

  // error, measurement change, saturating integral
  always_comb begin
    err      = EW'(setpoint) - EW'(measurement);
    delta    = EW'(measurement) - EW'(last_meas_r);
    sum_wide = (SW+1)'(isum_r) + (SW+1)'(err);
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
  end

  // state update; the arming item leaves the integral alone
  always_comb begin
    armed_nxt     = armed_r;
    isum_nxt      = isum_r;
    last_meas_nxt = last_meas_r;
    if (accept) begin
      armed_nxt = 1'b1;
      if (!armed_r) begin
        last_meas_nxt = '0;
      end else begin
        isum_nxt      = sum_sat;
        last_meas_nxt = measurement;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      isum_r      <= '0;
      last_meas_r <= '0;
    end else begin
      armed_r     <= armed_nxt;
      isum_r      <= isum_nxt;
      last_meas_r <= last_meas_nxt;
    end
  end

  assign task_out.first = !armed_r;
  assign task_out.err   = err;
  assign task_out.isum  = sum_sat;
  assign task_out.delta = delta;

endmodule

/* hdl/pidc_back.sv */
// Back end: three products in one stage, then sum and clamp into the result queue.
// Depends on pidc_pkg for the task record, gains and widths.
module pidc_back #(
  parameter int OUT_DEPTH = pidc_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pidc_pkg::gains_t                 gains,
  input  pidc_pkg::task_t                  task_in,
  input  logic                             task_empty,
  output logic                             task_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
  output logic                             res_push,
  output logic [pidc_pkg::DATA_W-1:0]      res_drive
);

  localparam int PW    = pidc_pkg::PROD_PD_W;
  localparam int IW    = pidc_pkg::PROD_I_W;
  localparam int AW    = pidc_pkg::ACC_W;
  localparam int DW    = pidc_pkg::DATA_W;
  localparam int CNT_W = $clog2(OUT_DEPTH+1);

  logic                 s1_v_r;
  logic                 s1_first_r;
  logic signed [PW-1:0] prod_p_r;
  logic signed [IW-1:0] prod_i_r;
  logic signed [PW-1:0] prod_d_r;
  logic [CNT_W:0]       pending;
  logic signed [AW-1:0] acc;
  logic [DW-1:0]        drive;

  // issue only when the result queue has room for everything in flight
  assign pending  = (CNT_W+1)'(out_count) + (CNT_W+1)'(s1_v_r);
  assign task_pop = !task_empty && (pending < (CNT_W+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= task_pop;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (task_pop) begin
      s1_first_r <= task_in.first;
      prod_p_r   <= PW'(gains.kp) * PW'(task_in.err);
      prod_i_r   <= IW'(gains.ki) * IW'(task_in.isum);
      prod_d_r   <= PW'(gains.kd) * PW'(task_in.delta);
    end
  end

  // exact sum and clamp to the drive range; the first item drives zero
  always_comb begin
    acc = AW'(prod_p_r) + AW'(prod_i_r) - AW'(prod_d_r);
    if (s1_first_r || acc[AW-1]) begin
      drive = '0;
    end else if (acc[AW-2:DW] != '0) begin
      drive = pidc_pkg::DRIVE_MAX;
    end else begin
      drive = acc[DW-1:0];
    end
  end

  assign res_push  = s1_v_r;
  assign res_drive = drive;

endmodule

/* hdl/pid_controller_step.sv */
// PID step, derivative on measurement. The front classifies each sample into
// a queue, then come the product stage and the sum/clamp into the result queue.
// Throughput: one item per cycle while the result queue has room, set by the single product stage.
// Reset: synchronous, active low; clears gains, arming, integral, queues.
module pid_controller_step #(
  parameter int MID_DEPTH = pidc_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = pidc_pkg::OUT_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample queue side
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [pidc_pkg::DATA_W-1:0]   in_setpoint,
  input  logic signed [pidc_pkg::DATA_W-1:0]   in_measurement,
  // result queue side
  output logic                                 empty,
  input  logic                                 pop,
  output logic [pidc_pkg::DATA_W-1:0]          out_drive,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pidc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [pidc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int TW = $bits(pidc_pkg::task_t);

  pidc_pkg::gains_t                 gains;
  pidc_pkg::task_t                  front_task;
  pidc_pkg::task_t                  back_task;
  logic [TW-1:0]                    back_task_bits;
  logic                             accept;
  logic                             mid_empty;
  logic                             mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0]   mid_count;
  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;
  logic                             res_push;
  logic [pidc_pkg::DATA_W-1:0]      res_drive;
  logic                             out_full;

  assign accept    = push && !full;
  assign back_task = pidc_pkg::task_t'(back_task_bits);

  pidc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  pidc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .setpoint    (in_setpoint),
    .measurement (in_measurement),
    .task_out    (front_task)
  );

  // queue between front and back
  pidc_fifo #(
    .WIDTH (TW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_task),
    .full  (full),
    .pop   (mid_pop),
    .rdata (back_task_bits),
    .empty (mid_empty),
    .count (mid_count)
  );

  pidc_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .gains      (gains),
    .task_in    (back_task),
    .task_empty (mid_empty),
    .task_pop   (mid_pop),
    .out_count  (out_count),
    .res_push   (res_push),
    .res_drive  (res_drive)
  );

  // result queue; back end never pushes into a full one
  pidc_fifo #(
    .WIDTH (pidc_pkg::DATA_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push && !(mid_count == '1 && out_full)),
    .wdata (res_drive),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_drive),
    .empty (empty),
    .count (out_count)
  );

endmodule

/* hdl/pidc_checker.sv */
// Port-level checker for the PID step block, bound to the top level.
// Depends on pidc_pkg and pid_controller_step_macros.svh.
`include "pid_controller_step_macros.svh"

module pidc_checker #(
  parameter int MID_DEPTH = pidc_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = pidc_pkg::OUT_DEPTH_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [pidc_pkg::DATA_W-1:0] out_drive,
  input logic                        pready
);

  localparam int CAP   = MID_DEPTH + OUT_DEPTH + 1;
  localparam int OUT_W = $clog2(CAP + 2);

  // items taken in and not yet delivered
  logic [OUT_W-1:0] outstanding_r, outstanding_nxt;
  logic             in_acc, out_acc;

  assign in_acc          = push && !full;
  assign out_acc         = pop && !empty;
  assign outstanding_nxt = outstanding_r + OUT_W'(in_acc) - OUT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  `PIDC_ASSERT_NOW(a_no_invented_result, !empty, outstanding_r != '0)
  `PIDC_ASSERT_NOW(a_capacity, 1'b1, outstanding_r <= OUT_W'(CAP))
  `PIDC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_drive))
  `PIDC_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind pid_controller_step pidc_checker #(
  .MID_DEPTH (MID_DEPTH),
  .OUT_DEPTH (OUT_DEPTH)
) u_pidc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_drive (out_drive),
  .pready    (pready)
);
